>>> rtl/core/drawdown_tracker_defines.svh
// assertion macros for the drawdown tracker rtl, used by dt_ctrl
`ifndef DRAWDOWN_TRACKER_DEFINES_SVH
`define DRAWDOWN_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
// checked on every edge out of reset
`define DT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define DT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DT_ASSERT(lbl, prop, msg)
`define DT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/core/dt_pkg.sv
`timescale 1ns / 1ps

package dt_pkg;

  // defaults for the top level parameters
  localparam int VALUE_BITS_DEF    = 32;
  localparam int FRACTION_BITS_DEF = 16;

  // fixed field widths
  localparam int TIME_W   = 48;
  localparam int THRESH_W = 16;
  localparam int LEN_W    = 16;
  localparam int FRAC_W   = 16;

  // result tdata: six fields, 160 bits, already whole bytes
  localparam int OUT_DATA_W = FRAC_W + TIME_W + TIME_W + LEN_W + LEN_W + FRAC_W;

  // about 0.01 in Q0.16
  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd655;

  // register map
  localparam int          ADDR_W              = 3;
  localparam logic [0:0]  REG_EPISODE_THRESH  = 1'b0;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the accepted sample
    logic div_init;  // seed the fraction divider
    logic div_step;  // one quotient bit
    logic update;    // commit the analysis state and result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;  // not a seed, and a nonzero value at or below a nonzero peak
    logic div_last;  // final quotient bit this cycle
  } dp_status_t;

endpackage

>>> rtl/core/drawdown_tracker.sv
`timescale 1ns / 1ps
// drawdown_tracker: running maximum-drawdown analysis of an equity series
// input stream (s_*): one equity sample per transaction, value and timestamp
//   in s_tdata, the series-start flag in s_tuser; a set flag clears the
//   analysis and seeds the peak with that sample
// output stream (m_*): exactly one result per sample, in order, carrying the
//   worst drawdown, its start time, last recovery time and lengths, the
//   drawdown of this sample, and the open-episode flag in m_tuser
// apb port: one register, episode_threshold at byte address 0, Q0.16;
//   write it only while no sample is in flight
// sequence: each accepted sample is checked, then, if it is a drawdown
//   sample, divided by the restoring divider producing one quotient bit a
//   cycle, then committed; a seed, a new peak, a zero peak or a zero value
//   skips the divider; one sample is worked on at a time, so no new sample
//   is taken until the current one is committed
// stalls: a finished result sits in the output slot while the next sample is
//   taken and divided; that sample then waits at its commit step until the
//   slot is emptied, and s_tready stays low meanwhile
// reset (rst, synchronous): clears the analysis, empties the output slot and
//   sets episode_threshold to 655 (about 0.01)

module drawdown_tracker import dt_pkg::*; #(
  parameter int VALUE_BITS    = VALUE_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // apb configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // sample stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // equity_value [VALUE_BITS-1:0], sample_time above it, zero padded
  input  logic [((VALUE_BITS + TIME_W + 7) / 8) * 8 - 1:0] s_tdata,
  // series_start
  input  logic                 s_tuser,
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // worst_drawdown, worst_start_time, recovery_time, longest_episode,
  // last_recovery_length, sample_drawdown
  output logic [OUT_DATA_W-1:0] m_tdata,
  // episode_active
  output logic                 m_tuser
);

  logic [THRESH_W-1:0] episode_threshold;
  logic                cfg_write;
  logic                reg_hit;
  dp_cmd_t             cmd;
  dp_status_t          status;

  logic [FRAC_W-1:0] worst_drawdown;
  logic [TIME_W-1:0] worst_start_time;
  logic [TIME_W-1:0] recovery_time;
  logic [LEN_W-1:0]  longest_episode;
  logic [LEN_W-1:0]  last_recovery_length;
  logic [FRAC_W-1:0] sample_drawdown;
  logic              episode_active;

  // register index is the word address; one register in the map
  assign reg_hit   = (paddr[ADDR_W-1:2] == REG_EPISODE_THRESH);
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      episode_threshold <= THRESH_RESET;
    end else if (cfg_write && reg_hit) begin
      episode_threshold <= pwdata[THRESH_W-1:0];
    end
  end

  // read mux, unmapped words read as zero
  assign prdata = reg_hit ? 32'(episode_threshold) : 32'd0;

  // sequencer: capture, divide, commit
  dt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // sample capture, fraction divider and analysis state; the state registers
  // only change at commit, so they double as the output slot
  dt_datapath #(
    .VALUE_BITS    (VALUE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .status               (status),
    .in_value             (s_tdata[VALUE_BITS-1:0]),
    .in_time              (s_tdata[VALUE_BITS +: TIME_W]),
    .in_start             (s_tuser),
    .threshold            (episode_threshold),
    .worst_drawdown       (worst_drawdown),
    .worst_start_time     (worst_start_time),
    .recovery_time        (recovery_time),
    .longest_episode      (longest_episode),
    .last_recovery_length (last_recovery_length),
    .sample_drawdown      (sample_drawdown),
    .episode_active       (episode_active)
  );

  // first field in the lowest bits
  assign m_tdata = {sample_drawdown, last_recovery_length, longest_episode,
                    recovery_time, worst_start_time, worst_drawdown};
  assign m_tuser = episode_active;

endmodule

>>> rtl/core/dt_ctrl.sv
`timescale 1ns / 1ps
`include "drawdown_tracker_defines.svh"

module dt_ctrl import dt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_UPDATE
  } state_t;

  state_t state;
  logic   slot_free;

  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE);

  always_comb begin
    cmd.load     = (state == S_IDLE) && s_tvalid;
    cmd.div_init = (state == S_CHECK);
    cmd.div_step = (state == S_DIV);
    cmd.update   = (state == S_UPDATE) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // a commit refills the slot even when the old result leaves this cycle
      if (cmd.update) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= status.need_div ? S_DIV : S_UPDATE;
        end
        S_DIV: begin
          if (status.div_last) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `DT_ASSERT(a_one_at_a_time, (s_tvalid && s_tready |=> !s_tready), "second sample taken early")
  `DT_ASSERT(a_update_slot_free, (cmd.update |-> slot_free), "result overwritten while pending")
  `DT_ASSERT(a_update_shows, (cmd.update |=> m_tvalid), "committed result not presented")
  `DT_ASSERT_ALWAYS(a_cmd_exclusive, (cmd.load |-> !cmd.update && !cmd.div_step),
    "load overlaps update or divide")

endmodule

>>> rtl/core/dt_datapath.sv
`timescale 1ns / 1ps

module dt_datapath import dt_pkg::*; #(
  parameter int VALUE_BITS    = VALUE_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic [TIME_W-1:0]     in_time,
  input  logic                  in_start,
  input  logic [THRESH_W-1:0]   threshold,
  output logic [FRAC_W-1:0]     worst_drawdown,
  output logic [TIME_W-1:0]     worst_start_time,
  output logic [TIME_W-1:0]     recovery_time,
  output logic [LEN_W-1:0]      longest_episode,
  output logic [LEN_W-1:0]      last_recovery_length,
  output logic [FRAC_W-1:0]     sample_drawdown,
  output logic                  episode_active
);

  localparam int CNT_W = (FRACTION_BITS > 1) ? $clog2(FRACTION_BITS) : 1;
  localparam int CMP_W = (FRACTION_BITS > THRESH_W) ? FRACTION_BITS : THRESH_W;
  localparam logic [FRACTION_BITS-1:0] FRAC_MAX = '1;
  localparam logic [LEN_W-1:0]         LEN_MAX  = '1;
  localparam logic [CNT_W-1:0]         CNT_LAST = CNT_W'(FRACTION_BITS - 1);

  // captured sample
  logic [VALUE_BITS-1:0] val_q;
  logic [TIME_W-1:0]     time_q;
  logic                  start_q;

  // divider
  logic [VALUE_BITS-1:0]    rem;
  logic [FRACTION_BITS-1:0] quo;
  logic [CNT_W-1:0]         cnt;
  logic [VALUE_BITS:0]      rem_shift;
  logic [VALUE_BITS:0]      rem_diff;
  logic                     rem_ge;

  // analysis state
  logic [VALUE_BITS-1:0]    peak_value;
  logic [TIME_W-1:0]        episode_start;
  logic                     in_episode;
  logic [LEN_W-1:0]         episode_length;
  logic [FRACTION_BITS-1:0] max_drop;
  logic [TIME_W-1:0]        max_drop_start;
  logic [TIME_W-1:0]        episode_end;
  logic [LEN_W-1:0]         longest_length;
  logic [LEN_W-1:0]         recovery_length;
  logic [FRACTION_BITS-1:0] dd_q;

  // update terms
  logic                     new_peak;
  logic [FRACTION_BITS-1:0] dd;
  logic                     open_episode;
  logic                     in_episode_next;
  logic [LEN_W-1:0]         len_base;
  logic [LEN_W-1:0]         len_next;

  assign new_peak = val_q > peak_value;

  assign status.need_div = !start_q && !new_peak && (peak_value != '0) && (val_q != '0);
  assign status.div_last = cmd.div_step && (cnt == CNT_LAST);

  assign rem_shift = {rem, 1'b0};
  assign rem_diff  = rem_shift - {1'b0, peak_value};
  assign rem_ge    = rem_shift >= {1'b0, peak_value};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_q   <= in_value;
      time_q  <= in_time;
      start_q <= in_start;
    end
    if (cmd.div_init) begin
      rem <= peak_value - val_q;
      quo <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      rem <= rem_ge ? rem_diff[VALUE_BITS-1:0] : rem_shift[VALUE_BITS-1:0];
      quo <= {quo[FRACTION_BITS-2:0], rem_ge};
      cnt <= cnt + 1'b1;
    end
  end

  always_comb begin
    // no division when seeding, at a new peak or from a zero peak; a zero value gives full scale
    if (start_q || new_peak || (peak_value == '0)) begin
      dd = '0;
    end else if (val_q == '0) begin
      dd = FRAC_MAX;
    end else begin
      dd = quo;
    end
    open_episode    = !in_episode && (CMP_W'(dd) > CMP_W'(threshold));
    in_episode_next = in_episode || open_episode;
    len_base        = open_episode ? '0 : episode_length;
    len_next        = (len_base < LEN_MAX) ? len_base + 1'b1 : len_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_value      <= '0;
      episode_start   <= '0;
      in_episode      <= 1'b0;
      episode_length  <= '0;
      max_drop        <= '0;
      max_drop_start  <= '0;
      episode_end     <= '0;
      longest_length  <= '0;
      recovery_length <= '0;
      dd_q            <= '0;
    end else if (cmd.update) begin
      dd_q <= dd;
      if (start_q) begin
        peak_value      <= val_q;
        episode_start   <= time_q;
        in_episode      <= 1'b0;
        episode_length  <= '0;
        max_drop        <= '0;
        max_drop_start  <= '0;
        episode_end     <= '0;
        longest_length  <= '0;
        recovery_length <= '0;
      end else if (new_peak) begin
        peak_value <= val_q;
        if (in_episode) begin
          recovery_length <= episode_length;
          episode_end     <= time_q;
          in_episode      <= 1'b0;
          episode_length  <= '0;
        end
      end else begin
        if (dd > max_drop) begin
          max_drop       <= dd;
          max_drop_start <= episode_start;
        end
        if (open_episode) begin
          episode_start <= time_q;
        end
        in_episode <= in_episode_next;
        if (in_episode_next) begin
          episode_length <= len_next;
          if (len_next > longest_length) begin
            longest_length <= len_next;
          end
        end
      end
    end
  end

  assign worst_drawdown       = FRAC_W'(max_drop);
  assign worst_start_time     = max_drop_start;
  assign recovery_time        = episode_end;
  assign longest_episode      = longest_length;
  assign last_recovery_length = recovery_length;
  assign sample_drawdown      = FRAC_W'(dd_q);
  assign episode_active       = in_episode;

endmodule

>>> tb/tb_drawdown_tracker.sv
`timescale 1ns / 1ps

// drawdown tracker testbench: directed corners, threshold sweep, random equity walks,
// back-pressure stalls and a long episode followed by a recovery

module tb_drawdown_tracker;
  import dt_pkg::*;

  // widths at the default build
  localparam int VAL_W     = VALUE_BITS_DEF;
  localparam int IN_DATA_W = ((VAL_W + TIME_W + 7) / 8) * 8;

  // named values
  localparam logic [ADDR_W-1:0] THRESH_ADDR = ADDR_W'({REG_EPISODE_THRESH, 2'b00});
  localparam logic [LEN_W-1:0]  LEN_SAT     = '1;
  localparam logic [FRAC_W-1:0] FRAC_FULL   = '1;
  localparam logic [VAL_W-1:0]  VALUE_MAX   = '1;
  localparam logic [TIME_W-1:0] TIME_MAX    = '1;
  localparam int                HOLD_CYCLES = 300;
  localparam int                SETTLE      = FRACTION_BITS_DEF + 8;
  localparam int unsigned       EPISODE_RUN = 40;

  // one equity sample as it goes on the input stream
  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [VAL_W-1:0]  value;
    logic              start;
  } sample_t;

  // one analysis report as it comes off the output stream
  typedef struct packed {
    logic [FRAC_W-1:0] worst;
    logic [TIME_W-1:0] worst_start;
    logic [TIME_W-1:0] recovery;
    logic [LEN_W-1:0]  longest;
    logic [LEN_W-1:0]  last_len;
    logic [FRAC_W-1:0] drop;
    logic              active;
  } report_t;

  // running drawdown analysis kept alongside the block, plus the reports it still owes
  class drawdown_checker;
    logic [THRESH_W-1:0] threshold;
    logic [VAL_W-1:0]    peak;
    logic [TIME_W-1:0]   ep_start;
    logic                in_ep;
    logic [LEN_W-1:0]    ep_len;
    logic [FRAC_W-1:0]   max_drop;
    logic [TIME_W-1:0]   max_start;
    logic [TIME_W-1:0]   ep_end;
    logic [LEN_W-1:0]    longest;
    logic [LEN_W-1:0]    rec_len;
    report_t             owed[$];
    int unsigned         errors;
    int unsigned         seen;

    function new();
      threshold = THRESH_RESET;
      errors = 0;
      seen = 0;
      clear();
    endfunction

    function void clear();
      peak = '0;
      ep_start = '0;
      in_ep = 1'b0;
      ep_len = '0;
      max_drop = '0;
      max_start = '0;
      ep_end = '0;
      longest = '0;
      rec_len = '0;
    endfunction

    // floor((peak - value) / peak) in Q0.16, full scale when the value is zero
    function logic [FRAC_W-1:0] drop_fraction(logic [VAL_W-1:0] top, logic [VAL_W-1:0] value);
      logic [VAL_W-1:0]        diff;
      logic [VAL_W+FRAC_W-1:0] quo;
      if (top == '0)
        return '0;
      diff = top - value;
      if (diff >= top)
        return FRAC_FULL;
      quo = {diff, {FRAC_W{1'b0}}} / {{FRAC_W{1'b0}}, top};
      return quo[FRAC_W-1:0];
    endfunction

    function void set_threshold(logic [THRESH_W-1:0] value);
      threshold = value;
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    // advance the analysis by one accepted sample and queue the report it owes
    function void take_sample(logic [VAL_W-1:0] value, logic [TIME_W-1:0] stamp, logic start);
      logic [FRAC_W-1:0] drop;
      report_t           r;
      drop = '0;
      if (start) begin
        clear();
        peak = value;
        ep_start = stamp;
      end else if (value > peak) begin
        // new high closes any open episode
        peak = value;
        if (in_ep) begin
          rec_len = ep_len;
          ep_end = stamp;
          in_ep = 1'b0;
          ep_len = '0;
        end
      end else begin
        drop = drop_fraction(peak, value);
        // start time is whatever episode start is held, possibly stale
        if (drop > max_drop) begin
          max_drop = drop;
          max_start = ep_start;
        end
        if (!in_ep && drop > threshold) begin
          in_ep = 1'b1;
          ep_start = stamp;
          ep_len = '0;
        end
        if (in_ep) begin
          if (ep_len != LEN_SAT)
            ep_len++;
          if (ep_len > longest)
            longest = ep_len;
        end
      end
      r.worst = max_drop;
      r.worst_start = max_start;
      r.recovery = ep_end;
      r.longest = longest;
      r.last_len = rec_len;
      r.drop = drop;
      r.active = in_ep;
      owed.insert(owed.size(), r);
    endfunction

    task check_result(logic [OUT_DATA_W-1:0] data, logic user);
      report_t want;
      report_t got;
      seen++;
      if (owed.size() == 0) begin
        report($sformatf("result %0d arrived with no sample outstanding", seen));
        return;
      end
      want = owed.pop_front();
      got.worst = data[15:0];
      got.worst_start = data[63:16];
      got.recovery = data[111:64];
      got.longest = data[127:112];
      got.last_len = data[143:128];
      got.drop = data[159:144];
      got.active = user;
      if (got.worst !== want.worst)
        report($sformatf("result %0d worst_drawdown %h, want %h", seen, got.worst, want.worst));
      if (got.worst_start !== want.worst_start)
        report($sformatf("result %0d worst_start_time %h, want %h", seen, got.worst_start,
                         want.worst_start));
      if (got.recovery !== want.recovery)
        report($sformatf("result %0d recovery_time %h, want %h", seen, got.recovery,
                         want.recovery));
      if (got.longest !== want.longest)
        report($sformatf("result %0d longest_episode %h, want %h", seen, got.longest,
                         want.longest));
      if (got.last_len !== want.last_len)
        report($sformatf("result %0d last_recovery_length %h, want %h", seen, got.last_len,
                         want.last_len));
      if (got.drop !== want.drop)
        report($sformatf("result %0d sample_drawdown %h, want %h", seen, got.drop, want.drop));
      if (got.active !== want.active)
        report($sformatf("result %0d episode_active %b, want %b", seen, got.active,
                         want.active));
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;    // equity_value, sample_time
  logic                  s_tuser;    // series_start
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;    // worst_drawdown, worst_start_time, recovery_time,
                                     // longest_episode, last_recovery_length, sample_drawdown
  logic                  m_tuser;    // episode_active

  drawdown_checker tracker_model;

  // samples waiting to go out, and the knobs the stream processes read
  sample_t     stim_q[$];
  logic        tx_busy;
  bit          tx_idle;
  bit          rx_idle;
  bit          hold_request;

  // random walk state used to build believable equity series
  logic [VAL_W-1:0]  walk_value;
  logic [VAL_W-1:0]  walk_peak;
  logic [TIME_W-1:0] walk_time;

  drawdown_tracker dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // overall watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // sample source: pulls from stim_q, random gap before each transaction while tx_idle is set
  initial begin : sample_source
    sample_t     item;
    int unsigned gap;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    tx_busy = 1'b0;
    @(negedge clk);
    forever begin
      if (stim_q.size() == 0) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end else begin
        item = stim_q.pop_front();
        tx_busy = 1'b1;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= IN_DATA_W'({item.stamp, item.value});
        s_tuser <= item.start;
        do @(posedge clk); while (!(s_tvalid && s_tready));
        tx_busy = 1'b0;
        @(negedge clk);
      end
    end
  end

  // result sink: random stall before each transaction while rx_idle is set, long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_request) begin
        // block fills up and has to stall its input
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = rx_idle ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      @(negedge clk);
    end
  end

  // transaction monitor on both streams
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        tracker_model.take_sample(s_tdata[VAL_W-1:0], s_tdata[VAL_W+TIME_W-1:VAL_W], s_tuser);
      if (m_tvalid && m_tready)
        tracker_model.check_result(m_tdata, m_tuser);
    end
  end

  task automatic push_sample(logic [VAL_W-1:0] value, logic [TIME_W-1:0] stamp, logic start);
    sample_t s;
    s.value = value;
    s.stamp = stamp;
    s.start = start;
    stim_q.insert(stim_q.size(), s);
  endtask

  // every queued sample sent and every report back
  task automatic wait_drained();
    while (stim_q.size() != 0 || tx_busy || tracker_model.pending() != 0)
      @(negedge clk);
  endtask

  // apb write of the threshold, then read it back
  task automatic write_threshold(logic [THRESH_W-1:0] value);
    logic [31:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= THRESH_ADDR;
    pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    tracker_model.set_threshold(value);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== 32'(value))
      tracker_model.report($sformatf("episode_threshold read %h, want %h", rd, value));
  endtask

  // values leaning on the extremes
  function automatic logic [VAL_W-1:0] any_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1000);
      2: return VALUE_MAX - $urandom_range(0, 1000);
      default: return $urandom_range(1000, 10_000_000);
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] next_time();
    int unsigned pick;
    logic [63:0] wide;
    pick = $urandom_range(0, 99);
    wide = {$urandom, $urandom};
    if (pick < 3)
      walk_time = wide[TIME_W-1:0];
    else if (pick < 4)
      walk_time = TIME_MAX;
    else
      walk_time = walk_time + $urandom_range(1, 5000);
    return walk_time;
  endfunction

  // mostly equity walks after a seed: climbs, slides, deep drops and recoveries to the peak,
  // with some noise and fresh seeds mid-series
  task automatic random_samples(int unsigned count);
    logic [VAL_W-1:0] value;
    logic [63:0]      cut;
    logic             start;
    int unsigned      pick;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      start = 1'b0;
      if (i == 0 || pick < 4) begin
        start = 1'b1;
        value = any_value();
        walk_peak = value;
      end else if (pick < 35) begin
        // climb a little, clamp at full scale
        cut = 64'(walk_value) + $urandom_range(0, walk_value / 50 + 2);
        value = (cut > 64'(VALUE_MAX)) ? VALUE_MAX : cut[VAL_W-1:0];
      end else if (pick < 80) begin
        // slide down by up to six percent
        cut = (64'(walk_value) * $urandom_range(0, 600)) / 10000;
        value = walk_value - cut[VAL_W-1:0];
      end else if (pick < 86) begin
        value = walk_peak;
      end else if (pick < 90) begin
        cut = (64'(walk_value) * $urandom_range(0, 100)) / 100;
        value = cut[VAL_W-1:0];
      end else if (pick < 92) begin
        value = '0;
      end else if (pick < 94) begin
        value = VALUE_MAX;
      end else begin
        value = $urandom;
      end
      if (value > walk_peak)
        walk_peak = value;
      walk_value = value;
      push_sample(value, next_time(), start);
    end
  endtask

  initial begin : main
    logic [TIME_W-1:0] t0;
    tracker_model = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_request = 1'b0;
    walk_value = 32'd100_000;
    walk_peak = 32'd100_000;
    walk_time = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed corners at the reset threshold
    // no seed after reset: zero peak gives no drawdown, first value becomes the peak
    push_sample('0, '0, 1'b0);
    push_sample(32'd1000, TIME_MAX, 1'b0);
    // zero value saturates the fraction and opens an episode
    push_sample('0, 48'd5, 1'b0);
    push_sample(32'd1000, 48'd6, 1'b0);
    // full-scale value recovers and records the episode
    push_sample(VALUE_MAX, 48'd7, 1'b0);
    // drawdown exactly at the threshold stays closed, one lsb above opens
    push_sample(32'h0001_0000, TIME_MAX, 1'b1);
    push_sample(32'h0001_0000 - 32'd655, 48'd9, 1'b0);
    push_sample(32'h0001_0000 - 32'd656, 48'd10, 1'b0);
    push_sample(32'h0001_0000 - 32'd100, 48'd11, 1'b0);
    push_sample(32'h0001_0001, 48'd12, 1'b0);
    push_sample(32'h0001_0000 - 32'd700, 48'd13, 1'b0);
    push_sample(32'h0001_0002, 48'd14, 1'b0);
    // worst set below the threshold keeps the seed time as its start
    push_sample(32'h0001_0000, 48'd100, 1'b1);
    push_sample(32'h0001_0000 - 32'd300, 48'd101, 1'b0);
    // seed with zero, then zero again against a zero peak
    push_sample('0, 48'd20, 1'b1);
    push_sample('0, 48'd21, 1'b0);
    push_sample(VALUE_MAX, 48'd22, 1'b0);
    push_sample(32'd1, 48'd23, 1'b0);
    push_sample(32'd5, '0, 1'b1);
    push_sample(32'd5, 48'd1, 1'b0);
    push_sample(VALUE_MAX, TIME_MAX, 1'b1);
    push_sample('0, TIME_MAX, 1'b0);
    wait_drained();

    // any drawdown opens an episode
    write_threshold('0);
    random_samples(200);
    wait_drained();

    // nothing can exceed full scale, no episodes; no idling on either side
    write_threshold('1);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    random_samples(150);
    wait_drained();
    tx_idle = 1'b1;
    rx_idle = 1'b1;

    // random threshold with a long output hold-off that stalls the input, then a second run
    write_threshold(THRESH_W'($urandom_range(50, 5000)));
    hold_request = 1'b1;
    random_samples(100);
    wait_drained();
    random_samples(150);
    wait_drained();

    // back to the reset value
    write_threshold(THRESH_RESET);
    random_samples(200);
    wait_drained();

    // one long episode back to back, then recover and slide again
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    t0 = 48'h1000;
    push_sample(32'd1000, t0, 1'b1);
    for (int unsigned i = 1; i <= EPISODE_RUN; i++)
      push_sample(32'd500, t0 + i, 1'b0);
    push_sample(32'd2000, TIME_MAX, 1'b0);
    push_sample(32'd1500, '0, 1'b0);
    wait_drained();
    repeat (SETTLE) @(negedge clk);

    if (tracker_model.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/dt_pkg.sv
rtl/core/dt_ctrl.sv
rtl/core/dt_datapath.sv
rtl/core/drawdown_tracker.sv
tb/tb_drawdown_tracker.sv
